>>> hw/rtl/vfc_pkg.sv
// Shared types, constants and the face table for the voxel face culling block.
`timescale 1ns / 1ps

package vfc_pkg;

    // Store geometry
    localparam int MAX_CUBES  = 4096;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_CUBES);
    localparam int CNT_BITS   = IDX_BITS + 1;

    // Face and vertex fields
    localparam int NUM_FACES   = 6;
    localparam int FACE_BITS   = 3;
    localparam int NORM_BITS   = 3;
    localparam int CORNER_BITS = 4;
    localparam int NUM_VERTS   = 6;
    localparam int VTX_BITS    = 16;

    // Stream widths
    localparam int S_TDATA_BITS = 64;
    localparam int M_TDATA_BITS = 120;
    localparam int OP_BITS      = 2;
    localparam int STATUS_BITS  = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_DRAWN   = 2'd0,
        STAT_HIDDEN  = 2'd1,
        STAT_MISSING = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_EMIT
    } state_t;

    // One stored cube: raw two's complement coordinates and the opaque flag.
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic                  opaque;
    } cube_t;

    // Per-face constants: neighbor offset, normal and the six triangle corners.
    typedef struct packed {
        logic [1:0]                            dx;
        logic [1:0]                            dy;
        logic [1:0]                            dz;
        logic [NORM_BITS-1:0]                  normal;
        logic [NUM_VERTS-1:0][CORNER_BITS-1:0] corner;
    } face_info_t;

    // One result transfer, before packing onto the master side.
    typedef struct packed {
        logic [IDX_BITS-1:0]                cube_id;
        logic [FACE_BITS-1:0]               face_dir;
        logic [NORM_BITS-1:0]               normal;
        logic [NUM_VERTS-1:0][VTX_BITS-1:0] vtx;
        status_t                            status;
        logic                               last;
    } result_t;

    // Offsets are two-bit two's complement; corner[0] is the first triangle's first vertex.
    function automatic face_info_t face_info(input logic [FACE_BITS-1:0] f);
        face_info_t r;
        r = '0;
        unique case (f)
            3'd0: begin
                r.dx = 2'b00; r.dy = 2'b00; r.dz = 2'b11; r.normal = 3'd2;
                r.corner = {4'd7, 4'd3, 4'd1, 4'd5, 4'd7, 4'd1};
            end
            3'd1: begin
                r.dx = 2'b11; r.dy = 2'b00; r.dz = 2'b00; r.normal = 3'd6;
                r.corner = {4'd4, 4'd2, 4'd1, 4'd3, 4'd4, 4'd1};
            end
            3'd2: begin
                r.dx = 2'b00; r.dy = 2'b01; r.dz = 2'b00; r.normal = 3'd3;
                r.corner = {4'd8, 4'd4, 4'd3, 4'd7, 4'd8, 4'd3};
            end
            3'd3: begin
                r.dx = 2'b01; r.dy = 2'b00; r.dz = 2'b00; r.normal = 3'd5;
                r.corner = {4'd6, 4'd8, 4'd5, 4'd8, 4'd7, 4'd5};
            end
            3'd4: begin
                r.dx = 2'b00; r.dy = 2'b11; r.dz = 2'b00; r.normal = 3'd4;
                r.corner = {4'd2, 4'd6, 4'd1, 4'd6, 4'd5, 4'd1};
            end
            3'd5: begin
                r.dx = 2'b00; r.dy = 2'b00; r.dz = 2'b01; r.normal = 3'd1;
                r.corner = {4'd4, 4'd8, 4'd2, 4'd8, 4'd6, 4'd2};
            end
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/vfc_cube_ram.sv
// Cube store: one write port and one registered read port.
`timescale 1ns / 1ps

module vfc_cube_ram (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [vfc_pkg::IDX_BITS-1:0]  wr_addr,
    input  vfc_pkg::cube_t                wr_data,
    input  logic                          rd_en,
    input  logic [vfc_pkg::IDX_BITS-1:0]  rd_addr,
    output vfc_pkg::cube_t                rd_data
);

    vfc_pkg::cube_t mem [vfc_pkg::MAX_CUBES];
    vfc_pkg::cube_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/vfc_nbr_match.sv
// Compares one stored cube against all six neighbor cells of the queried cube.
`timescale 1ns / 1ps

module vfc_nbr_match (
    input  vfc_pkg::cube_t                 center,
    input  vfc_pkg::cube_t                 cand,
    input  logic                           cand_valid,
    output logic [vfc_pkg::NUM_FACES-1:0]  hit
);

    localparam int CW = vfc_pkg::COORD_BITS + 1;

    // The candidate, widened by one bit so that edge neighbors never wrap.
    logic [CW-1:0] cx_w, cy_w, cz_w;

    assign cx_w = {cand.x[vfc_pkg::COORD_BITS-1], cand.x};
    assign cy_w = {cand.y[vfc_pkg::COORD_BITS-1], cand.y};
    assign cz_w = {cand.z[vfc_pkg::COORD_BITS-1], cand.z};

    // One comparator per face, all in parallel.
    for (genvar f = 0; f < vfc_pkg::NUM_FACES; f++) begin : g_face
        vfc_pkg::face_info_t info;
        logic [CW-1:0] nx, ny, nz;

        assign info = vfc_pkg::face_info(vfc_pkg::FACE_BITS'(f));
        assign nx = {center.x[vfc_pkg::COORD_BITS-1], center.x}
                  + {{(CW-2){info.dx[1]}}, info.dx};
        assign ny = {center.y[vfc_pkg::COORD_BITS-1], center.y}
                  + {{(CW-2){info.dy[1]}}, info.dy};
        assign nz = {center.z[vfc_pkg::COORD_BITS-1], center.z}
                  + {{(CW-2){info.dz[1]}}, info.dz};
        assign hit[f] = cand_valid && cand.opaque
                     && (nx == cx_w) && (ny == cy_w) && (nz == cz_w);
    end

endmodule

>>> hw/rtl/voxel_face_culling.sv
// Top level of the voxel face culling block: control sequencer and output register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   tuser opcode, tdata cube position and index
// m_        out        m_tvalid/m_tready   tuser status, tlast, tdata face and vertices
//
// Clear, append and unused opcodes are handled in the idle state on acceptance.
// A query of an index that is not stored goes from the idle state straight to
// the emit state; a query of a non-opaque cube reads the cube in the load state
// and then emits every face, one per cycle while m_tready is high.
// A query of an opaque cube scans the store through its single read port,
// one cube per cycle, and then emits its faces that are not hidden.
// Reset clears the state, the cube count and the valid flags; the store needs no clearing pass.
// A stalled m_tready holds the face sequence; no input is taken during a query.

module voxel_face_culling (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x[15:0], pos_y[31:16], pos_z[47:32], opaque_in[48], cube_index[60:49]
    input  logic [vfc_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // opcode[1:0]
    input  logic [vfc_pkg::OP_BITS-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cube_id[11:0], face_dir[14:12], normal_index[17:15], tri1_v1[33:18],
    // tri1_v2[49:34], tri1_v3[65:50], tri2_v1[81:66], tri2_v2[97:82], tri2_v3[113:98]
    output logic [vfc_pkg::M_TDATA_BITS-1:0]   m_tdata,
    // status[1:0]
    output logic [vfc_pkg::STATUS_BITS-1:0]    m_tuser,
    output logic                               m_tlast
);

    localparam int IDXW = vfc_pkg::IDX_BITS;
    localparam int CNTW = vfc_pkg::CNT_BITS;
    localparam int NF   = vfc_pkg::NUM_FACES;

    vfc_pkg::state_t   state_reg,  state_next;
    logic [CNTW-1:0]   count_reg,  count_next;
    logic [CNTW-1:0]   issue_reg,  issue_next;
    logic              dvalid_reg, dvalid_next;
    vfc_pkg::cube_t    center_reg, center_next;
    logic [IDXW-1:0]   qidx_reg,   qidx_next;
    logic [NF-1:0]     hidden_reg, hidden_next;
    logic [NF-1:0]     rem_reg,    rem_next;
    vfc_pkg::status_t  stat_reg,   stat_next;
    vfc_pkg::result_t  out_reg,    out_next;
    logic              mval_reg,   mval_next;

    vfc_pkg::opcode_t  s_op;
    vfc_pkg::cube_t    in_cube;
    logic [IDXW-1:0]   in_idx;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [IDXW-1:0]   ram_rd_addr;
    vfc_pkg::cube_t    ram_rd_data;
    logic [NF-1:0]     hit;

    logic                           out_free;
    logic [vfc_pkg::FACE_BITS-1:0]  sel_dir;
    vfc_pkg::face_info_t            sel_info;
    logic [vfc_pkg::VTX_BITS-1:0]   vtx_base;

    // Input field unpacking.
    assign s_op    = vfc_pkg::opcode_t'(s_tuser);
    assign in_cube = '{x:      s_tdata[15:0],
                       y:      s_tdata[31:16],
                       z:      s_tdata[47:32],
                       opaque: s_tdata[48]};
    assign in_idx  = s_tdata[60:49];

    vfc_cube_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[IDXW-1:0]),
        .wr_data (in_cube),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    vfc_nbr_match u_match (
        .center     (center_reg),
        .cand       (ram_rd_data),
        .cand_valid (dvalid_reg),
        .hit        (hit)
    );

    // Lowest remaining face goes out next.
    always_comb begin
        sel_dir = '0;
        for (int f = NF - 1; f >= 0; f--) begin
            if (rem_reg[f]) begin
                sel_dir = vfc_pkg::FACE_BITS'(f);
            end
        end
    end

    assign sel_info = vfc_pkg::face_info(sel_dir);
    assign vtx_base = {1'b0, qidx_reg, 3'b000};
    assign out_free = !mval_reg || m_tready;

    // Next state and datapath control.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        issue_next  = issue_reg;
        dvalid_next = dvalid_reg;
        center_next = center_reg;
        qidx_next   = qidx_reg;
        hidden_next = hidden_reg;
        rem_next    = rem_reg;
        stat_next   = stat_reg;
        out_next    = out_reg;
        mval_next   = mval_reg && !m_tready;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        s_tready    = 1'b0;

        unique case (state_reg)
            vfc_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_op)
                        vfc_pkg::OP_CLEAR: begin
                            count_next = '0;
                        end
                        vfc_pkg::OP_APPEND: begin
                            if (count_reg < CNTW'(vfc_pkg::MAX_CUBES)) begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CNTW'(1);
                            end
                        end
                        vfc_pkg::OP_QUERY: begin
                            qidx_next = in_idx;
                            if ({1'b0, in_idx} >= count_reg) begin
                                rem_next   = '0;
                                stat_next  = vfc_pkg::STAT_MISSING;
                                state_next = vfc_pkg::S_EMIT;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = in_idx;
                                state_next  = vfc_pkg::S_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            vfc_pkg::S_LOAD: begin
                // The queried cube is on the read port; start the scan if it is opaque.
                center_next = ram_rd_data;
                hidden_next = '0;
                stat_next   = vfc_pkg::STAT_HIDDEN;
                if (ram_rd_data.opaque) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = '0;
                    issue_next  = CNTW'(1);
                    dvalid_next = 1'b1;
                    state_next  = vfc_pkg::S_SCAN;
                end else begin
                    rem_next   = '1;
                    state_next = vfc_pkg::S_EMIT;
                end
            end

            vfc_pkg::S_SCAN: begin
                hidden_next = hidden_reg | hit;
                if (issue_reg < count_reg) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = issue_reg[IDXW-1:0];
                    issue_next  = issue_reg + CNTW'(1);
                    dvalid_next = 1'b1;
                end else begin
                    dvalid_next = 1'b0;
                end
                if (!dvalid_reg) begin
                    rem_next   = ~hidden_reg;
                    state_next = vfc_pkg::S_EMIT;
                end
            end

            vfc_pkg::S_EMIT: begin
                if (out_free) begin
                    mval_next       = 1'b1;
                    out_next        = '0;
                    out_next.cube_id = qidx_reg;
                    if (rem_reg == '0) begin
                        // Index not stored, or every face hidden.
                        out_next.status = stat_reg;
                        out_next.last   = 1'b1;
                        state_next      = vfc_pkg::S_IDLE;
                    end else begin
                        rem_next          = rem_reg & ~(NF'(1) << sel_dir);
                        out_next.face_dir = sel_dir;
                        out_next.normal   = sel_info.normal;
                        out_next.status   = vfc_pkg::STAT_DRAWN;
                        for (int k = 0; k < vfc_pkg::NUM_VERTS; k++) begin
                            out_next.vtx[k] = vtx_base
                                + vfc_pkg::VTX_BITS'(sel_info.corner[k]);
                        end
                        out_next.last = (rem_next == '0);
                        if (rem_next == '0) begin
                            state_next = vfc_pkg::S_IDLE;
                        end
                    end
                end
            end

            default: state_next = vfc_pkg::S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= vfc_pkg::S_IDLE;
            count_reg  <= '0;
            dvalid_reg <= 1'b0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            dvalid_reg <= dvalid_next;
            mval_reg   <= mval_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        issue_reg  <= issue_next;
        center_reg <= center_next;
        qidx_reg   <= qidx_next;
        hidden_reg <= hidden_next;
        rem_reg    <= rem_next;
        stat_reg   <= stat_next;
        out_reg    <= out_next;
    end

    // Output packing.
    assign m_tvalid = mval_reg;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {6'd0,
                       out_reg.vtx[5], out_reg.vtx[4], out_reg.vtx[3],
                       out_reg.vtx[2], out_reg.vtx[1], out_reg.vtx[0],
                       out_reg.normal, out_reg.face_dir, out_reg.cube_id};

    // The cube count never passes the store depth.
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(vfc_pkg::MAX_CUBES))
        else $error("cube count beyond store depth");

    // The scan never reads past the stored cubes.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vfc_pkg::S_SCAN) |-> (issue_reg <= count_reg))
        else $error("scan address beyond cube count");

    // A result only appears out of the emit state.
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == vfc_pkg::S_EMIT))
        else $error("result appeared outside the emit state");

    // A result without a drawn face always ends its query.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != vfc_pkg::STAT_DRAWN)) |-> m_tlast)
        else $error("status result without last");

endmodule
